FILE: src/cbmf_pkg.sv
// ----------------------------------------------------------------------------
// cbmf_pkg: shared types and constants
// Payload structs, sequencer states and default sizes for the clipped box
// mean filter.
// ----------------------------------------------------------------------------
package cbmf_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 16;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_HEIGHT     = 4096;

  // fixed field widths
  localparam int ROW_W  = 12;
  localparam int HGT_W  = 13;
  localparam int WID_W  = 11;
  localparam int RAD_W  = 5;
  localparam int MEAN_W = 24;
  localparam int COL_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] gray_value;
  } in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              frame_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_ACC,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_t;

endpackage

FILE: src/cbmf_ram.sv
// ----------------------------------------------------------------------------
// cbmf_ram: generic single-write, single-read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cbmf_div.sv
// ----------------------------------------------------------------------------
// cbmf_div: radix-2 restoring divider
// Unsigned quotient of a DW-bit dividend by an NW-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module cbmf_div #(
  parameter int DW = 36,
  parameter int NW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [NW:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [NW+1:0]    trial;

  // one restoring step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, quo_r[DW-1]};
      if (trial >= {2'b00, divisor}) begin
        rem_nxt = (NW+1)'(trial - {2'b00, divisor});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = (NW+1)'(trial);
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: src/clipped_box_mean_filter.sv
// ----------------------------------------------------------------------------
// clipped_box_mean_filter: box mean with clipped borders
// Gray pixels come in raster order; each result is the mean of the clipped
// (2R+1)x(2R+1) window around one pixel, unsigned Q16.8 rounded down.
//
// Usage:
//   in_*  : one request per pixel (operation pixel) or drain tick; drain
//           ticks after the last pixel flush the bottom rows' results.
//   out_* : at most one result per input request, in raster order, given
//           once its window is complete; frame_last marks the final pixel.
//   cfg_* : register writes (width, height, radius); a write restarts the
//           frame. Always ready.
//   Per request: the block accepts it and checks whether a result is due; if
//   so, it sweeps the clipped rows x cols window, reading one line store word
//   in a read state and adding it in an accumulate state, then starts the
//   divider (DW bits wide, 36 by default), which retires one quotient bit a
//   cycle. in_ready is low from accept until the result has
//   been taken, so a stalled receiver holds the input side too.
//   Reset: positions return to the frame start and the registers to 640 x
//   480, radius 4; line store contents are left as they are.
// ----------------------------------------------------------------------------
module clipped_box_mean_filter #(
  parameter int MAX_WIDTH  = cbmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = cbmf_pkg::MAX_RADIUS_DEF,
  parameter int PIXEL_BITS = cbmf_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cbmf_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cbmf_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cbmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = CW + 1;
  localparam int LCW       = CW + 8;
  localparam int RADW      = $clog2(MAX_RADIUS + 1);
  localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SW        = $clog2(LINE_ROWS);
  localparam int CNTW      = 2 * SW;
  localparam int SUMW      = PIXEL_BITS + CNTW;
  localparam int DW        = SUMW + 8;
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int RW        = cbmf_pkg::ROW_W;
  localparam int HW        = cbmf_pkg::HGT_W;

  // configuration registers
  logic [cbmf_pkg::WID_W-1:0] width_r;
  logic [HW-1:0]              height_r;
  logic [cbmf_pkg::RAD_W-1:0] radius_r;
  logic                       cfg_hit;

  // frame positions
  logic [RW-1:0] in_row_r, in_row_nxt, emit_row_r, emit_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, emit_col_r, emit_col_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt, emit_slot_r, emit_slot_nxt;
  logic          in_done_r, in_done_nxt;

  // window sweep
  logic [RW-1:0]   lr_r, lr_nxt, r0_r, r0_nxt, row_r, row_nxt;
  logic [CW-1:0]   lc_r, lc_nxt, c0_r, c0_nxt, col_r, col_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [SW-1:0]   nrows_r, nrows_nxt, ncols_r, ncols_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            last_r, last_nxt;

  cbmf_pkg::state_t state_r, state_nxt;
  cbmf_pkg::out_t   res_r, res_nxt;

  // effective settings
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic [RADW-1:0] r_eff;
  logic [HW-1:0]   lr_sum;
  logic [LCW-1:0]  lc_sum;
  logic [RW-1:0]   lr_c, r0_c;
  logic [CW-1:0]   lc_c, c0_c;
  logic [SW-1:0]   dist_c;
  logic            win_ready;
  logic            accept;

  // ram and divider hookup
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PIXEL_BITS-1:0] ram_rdata;
  logic                  div_start, div_done;
  logic [DW-1:0]         div_quo;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == cbmf_pkg::REG_WIDTH ||
                     cfg_index == cbmf_pkg::REG_HEIGHT || cfg_index == cbmf_pkg::REG_RADIUS);
  assign accept    = in_valid && in_ready;

  // clamp out-of-range settings
  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > cbmf_pkg::MAX_HEIGHT) begin
      h_eff = HW'(cbmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    r_eff = (32'(radius_r) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(radius_r);
  end

  // window bounds for the next result
  always_comb begin
    lr_sum = HW'(emit_row_r) + HW'(r_eff);
    lr_c   = (lr_sum > h_eff - 1'b1) ? RW'(h_eff - 1'b1) : RW'(lr_sum);
    lc_sum = LCW'(emit_col_r) + LCW'(r_eff);
    lc_c   = (lc_sum > LCW'(w_eff - 1'b1)) ? CW'(w_eff - 1'b1) : CW'(lc_sum);
    r0_c   = (emit_row_r > RW'(r_eff)) ? RW'(emit_row_r - RW'(r_eff)) : '0;
    c0_c   = (LCW'(emit_col_r) > LCW'(r_eff)) ? CW'(emit_col_r - CW'(r_eff)) : '0;
    dist_c = SW'(emit_row_r - r0_c);
    win_ready = in_done_r || (lr_c < in_row_r) || (lr_c == in_row_r && lc_c < in_col_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbmf_pkg::ST_IDLE:  if (accept) state_nxt = cbmf_pkg::ST_CHECK;
      cbmf_pkg::ST_CHECK: state_nxt = win_ready ? cbmf_pkg::ST_RD : cbmf_pkg::ST_IDLE;
      cbmf_pkg::ST_RD:    state_nxt = cbmf_pkg::ST_ACC;
      cbmf_pkg::ST_ACC: begin
        if (col_r == lc_r && row_r == lr_r) begin
          state_nxt = cbmf_pkg::ST_DIVS;
        end else begin
          state_nxt = cbmf_pkg::ST_RD;
        end
      end
      cbmf_pkg::ST_DIVS:  state_nxt = cbmf_pkg::ST_DIVW;
      cbmf_pkg::ST_DIVW:  if (div_done) state_nxt = cbmf_pkg::ST_OUT;
      cbmf_pkg::ST_OUT:   if (out_ready) state_nxt = cbmf_pkg::ST_IDLE;
      default:            state_nxt = cbmf_pkg::ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_nxt = cbmf_pkg::ST_IDLE;
    end
  end

  // datapath and outputs
  always_comb begin
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    in_done_nxt  = in_done_r;
    emit_row_nxt = emit_row_r;
    emit_col_nxt = emit_col_r;
    emit_slot_nxt = emit_slot_r;
    lr_nxt    = lr_r;
    lc_nxt    = lc_r;
    r0_nxt    = r0_r;
    c0_nxt    = c0_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    slot_nxt  = slot_r;
    nrows_nxt = nrows_r;
    ncols_nxt = ncols_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    res_nxt   = res_r;
    in_ready  = (state_r == cbmf_pkg::ST_IDLE);
    out_valid = (state_r == cbmf_pkg::ST_OUT);
    ram_we    = 1'b0;
    ram_waddr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
    ram_raddr = AW'(slot_r) * AW'(MAX_WIDTH) + AW'(col_r);
    div_start = (state_r == cbmf_pkg::ST_DIVS);

    case (state_r)
      // store pixel and advance the input position
      cbmf_pkg::ST_IDLE: begin
        if (accept && in_data.operation == cbmf_pkg::OP_PIXEL && !in_done_r) begin
          ram_we = 1'b1;
          if (WW'(in_col_r) + 1'b1 >= w_eff) begin
            in_col_nxt = '0;
            if (HW'(in_row_r) + 1'b1 >= h_eff) begin
              in_row_nxt  = '0;
              in_slot_nxt = '0;
              in_done_nxt = 1'b1;
            end else begin
              in_row_nxt  = in_row_r + 1'b1;
              in_slot_nxt = (in_slot_r == SW'(LINE_ROWS - 1)) ? '0 : in_slot_r + 1'b1;
            end
          end else begin
            in_col_nxt = in_col_r + 1'b1;
          end
        end
      end
      // set up the sweep
      cbmf_pkg::ST_CHECK: begin
        lr_nxt    = lr_c;
        lc_nxt    = lc_c;
        r0_nxt    = r0_c;
        c0_nxt    = c0_c;
        row_nxt   = r0_c;
        col_nxt   = c0_c;
        slot_nxt  = (emit_slot_r >= dist_c) ? SW'(emit_slot_r - dist_c)
                                            : SW'(emit_slot_r + SW'(LINE_ROWS) - dist_c);
        nrows_nxt = SW'(lr_c - r0_c + 1'b1);
        ncols_nxt = SW'(lc_c - c0_c + 1'b1);
        sum_nxt   = '0;
        last_nxt  = (HW'(emit_row_r) == h_eff - 1'b1) && (WW'(emit_col_r) == w_eff - 1'b1);
      end
      // accumulate one word and step the cursor
      cbmf_pkg::ST_ACC: begin
        sum_nxt = sum_r + SUMW'(ram_rdata);
        if (col_r == lc_r) begin
          col_nxt = c0_r;
          if (row_r != lr_r) begin
            row_nxt  = row_r + 1'b1;
            slot_nxt = (slot_r == SW'(LINE_ROWS - 1)) ? '0 : slot_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
        count_nxt = CNTW'(nrows_r) * CNTW'(ncols_r);
      end
      // capture the quotient
      cbmf_pkg::ST_DIVW: begin
        if (div_done) begin
          res_nxt.mean_value = div_quo[cbmf_pkg::MEAN_W-1:0];
          res_nxt.out_row    = emit_row_r;
          res_nxt.out_col    = cbmf_pkg::COL_W'(emit_col_r);
          res_nxt.frame_last = last_r;
        end
      end
      // hand over the result and advance the emit position
      cbmf_pkg::ST_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            in_row_nxt    = '0;
            in_col_nxt    = '0;
            in_slot_nxt   = '0;
            in_done_nxt   = 1'b0;
            emit_row_nxt  = '0;
            emit_col_nxt  = '0;
            emit_slot_nxt = '0;
          end else if (WW'(emit_col_r) + 1'b1 >= w_eff) begin
            emit_col_nxt  = '0;
            emit_row_nxt  = emit_row_r + 1'b1;
            emit_slot_nxt = (emit_slot_r == SW'(LINE_ROWS - 1)) ? '0 : emit_slot_r + 1'b1;
          end else begin
            emit_col_nxt = emit_col_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // a register write restarts the frame
    if (cfg_hit) begin
      in_row_nxt    = '0;
      in_col_nxt    = '0;
      in_slot_nxt   = '0;
      in_done_nxt   = 1'b0;
      emit_row_nxt  = '0;
      emit_col_nxt  = '0;
      emit_slot_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbmf_pkg::ST_IDLE;
      width_r     <= cbmf_pkg::WID_W'(640);
      height_r    <= HW'(480);
      radius_r    <= cbmf_pkg::RAD_W'(4);
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      in_done_r   <= 1'b0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      emit_slot_r <= '0;
    end else begin
      state_r     <= state_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      in_done_r   <= in_done_nxt;
      emit_row_r  <= emit_row_nxt;
      emit_col_r  <= emit_col_nxt;
      emit_slot_r <= emit_slot_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          cbmf_pkg::REG_WIDTH:  width_r  <= cfg_data[cbmf_pkg::WID_W-1:0];
          cbmf_pkg::REG_HEIGHT: height_r <= cfg_data[HW-1:0];
          cbmf_pkg::REG_RADIUS: radius_r <= cfg_data[cbmf_pkg::RAD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // sweep and result registers
  always_ff @(posedge clk) begin
    lr_r    <= lr_nxt;
    lc_r    <= lc_nxt;
    r0_r    <= r0_nxt;
    c0_r    <= c0_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    slot_r  <= slot_nxt;
    nrows_r <= nrows_nxt;
    ncols_r <= ncols_nxt;
    sum_r   <= sum_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  assign out_data = res_r;

  // line store
  cbmf_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.gray_value[PIXEL_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared divider
  cbmf_div #(
    .DW (DW),
    .NW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, 8'h00}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

FILE: src/cbmf_checker.sv
// ----------------------------------------------------------------------------
// cbmf_checker: port-level checks
// Handshake and one-request-at-a-time checks, bound to the top level.
// ----------------------------------------------------------------------------
module cbmf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cbmf_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no new request while a result is shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // one result per request
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result repeated");

  // busy after accepting a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind clipped_box_mean_filter cbmf_checker u_cbmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/cbmf_mean_checker.sv
// ----------------------------------------------------------------------------
// cbmf_mean_checker: result checker for the clipped box mean filter
// Watches the register, pixel and result channels, predicts every window mean
// from its own copy of the line rows and positions, and compares each result
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module cbmf_mean_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  cbmf_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  cbmf_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cbmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbmf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_means,
  output bit                             frame_flushing
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_ROWS = 2 * cbmf_pkg::MAX_RADIUS_DEF + 2;
  localparam int MAX_W     = cbmf_pkg::MAX_WIDTH_DEF;
  localparam int MAX_R     = cbmf_pkg::MAX_RADIUS_DEF;
  localparam int MAX_H     = cbmf_pkg::MAX_HEIGHT;

  logic [15:0]    line_rows [LINE_ROWS*MAX_W];
  cbmf_pkg::out_t mean_queue [$];
  int unsigned    reg_w, reg_h, reg_r;
  int unsigned    row_in, col_in, row_out, col_out;

  // frame positions back to the start
  task automatic restart_frame();
    row_in = 0;
    col_in = 0;
    row_out = 0;
    col_out = 0;
    frame_flushing = 1'b0;
  endtask

  // take one request, queue the mean it releases, if any
  task automatic predict_mean(cbmf_pkg::in_t req);
    int unsigned w, h, r, lr, lc, r0, c0, cnt;
    longint unsigned acc;
    cbmf_pkg::out_t res;
    bit last;
    w = (reg_w == 0) ? 1 : (reg_w > MAX_W ? MAX_W : reg_w);
    h = (reg_h == 0) ? 1 : (reg_h > MAX_H ? MAX_H : reg_h);
    r = (reg_r > MAX_R) ? MAX_R : reg_r;
    if (req.operation == cbmf_pkg::OP_PIXEL && !frame_flushing) begin
      line_rows[(row_in % LINE_ROWS) * MAX_W + col_in] = req.gray_value;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
        if (row_in >= h) begin
          row_in = 0;
          frame_flushing = 1'b1;
        end
      end
    end
    lr = (row_out + r > h - 1) ? h - 1 : row_out + r;
    lc = (col_out + r > w - 1) ? w - 1 : col_out + r;
    if (!(frame_flushing || lr < row_in || (lr == row_in && lc < col_in))) return;
    r0 = (row_out > r) ? row_out - r : 0;
    c0 = (col_out > r) ? col_out - r : 0;
    acc = 0;
    for (int unsigned c = c0; c <= lc; c++)
      for (int unsigned rr = r0; rr <= lr; rr++)
        acc += line_rows[(rr % LINE_ROWS) * MAX_W + c];
    cnt = (lr - r0 + 1) * (lc - c0 + 1);
    last = (row_out == h - 1) && (col_out == w - 1);
    res.mean_value = cbmf_pkg::MEAN_W'((acc << 8) / cnt);
    res.out_row    = cbmf_pkg::ROW_W'(row_out);
    res.out_col    = cbmf_pkg::COL_W'(col_out);
    res.frame_last = last;
    mean_queue.push_back(res);
    if (last) begin
      restart_frame();
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    cbmf_pkg::out_t want;
    if (!rst_n) begin
      reg_w = 640;
      reg_h = 480;
      reg_r = 4;
      restart_frame();
      mean_queue.delete();
    end else begin
      // register write restarts the frame
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cbmf_pkg::REG_WIDTH:  reg_w = cfg_data & 13'h7FF;
          cbmf_pkg::REG_HEIGHT: reg_h = cfg_data & 13'h1FFF;
          cbmf_pkg::REG_RADIUS: reg_r = cfg_data & 13'h1F;
          default: ;
        endcase
        if (cfg_index == cbmf_pkg::REG_WIDTH || cfg_index == cbmf_pkg::REG_HEIGHT ||
            cfg_index == cbmf_pkg::REG_RADIUS)
          restart_frame();
      end
      if (in_valid && in_ready) predict_mean(in_data);
      // compare a result with the oldest predicted mean
      if (out_valid && out_ready) begin
        if (mean_queue.size() == 0) begin
          $error("unexpected result: row %0d col %0d mean %0d",
                 out_data.out_row, out_data.out_col, out_data.mean_value);
          fail_count++;
        end else begin
          want = mean_queue.pop_front();
          if (out_data.mean_value !== want.mean_value) begin
            $error("mean_value: expected %0d, got %0d", want.mean_value, out_data.mean_value);
            fail_count++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
            fail_count++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
            fail_count++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_data.frame_last);
            fail_count++;
          end
        end
      end
    end
    pending_means = mean_queue.size();
  end

  initial begin
    fail_count = 0;
    pending_means = 0;
    frame_flushing = 1'b0;
  end

endmodule

FILE: tb/clipped_box_mean_filter_test.sv
// ----------------------------------------------------------------------------
// clipped_box_mean_filter_test: top of the box mean filter testbench
// Drives register writes, pixel and drain requests with random idling and
// result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module clipped_box_mean_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  cbmf_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_ready;
  cbmf_pkg::out_t                  out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [cbmf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbmf_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              pending_means;
  bit                              frame_flushing;
  bit                              calm;
  int                              sent;

  clipped_box_mean_filter dut (.*);

  cbmf_mean_checker checker_i (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready = (stall == 0);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 6);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // one request; entered and left at a falling edge
  task automatic push_request(logic op, logic [15:0] gray);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.operation = op;
    in_data.gray_value = gray;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
  endtask

  // wait for an idle block, then write one register
  task automatic write_reg(logic [cbmf_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    in_valid = 1'b0;
    while (pending_means != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = cbmf_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
    write_reg(cbmf_pkg::REG_WIDTH, w);
    write_reg(cbmf_pkg::REG_HEIGHT, h);
    write_reg(cbmf_pkg::REG_RADIUS, r);
  endtask

  // drain requests until the frame's last mean has been released
  task automatic flush_frame();
    while (frame_flushing)
      push_request($urandom_range(0, 3) == 0 ? cbmf_pkg::OP_PIXEL : cbmf_pkg::OP_DRAIN,
                   16'($urandom));
  endtask

  function automatic logic [15:0] pick_gray();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned w, h, r, n, stop;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = cbmf_pkg::REG_WIDTH;
    cfg_data = '0;
    calm = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // drain with nothing ready, straight after reset
    push_request(cbmf_pkg::OP_DRAIN, 16'h0000);

    // small frame: extreme values, a drain mid-frame, pixel acting as drain
    set_frame(3, 2, 1);
    push_request(cbmf_pkg::OP_PIXEL, 16'h0000);
    push_request(cbmf_pkg::OP_DRAIN, 16'hFFFF);
    push_request(cbmf_pkg::OP_PIXEL, 16'hFFFF);
    push_request(cbmf_pkg::OP_PIXEL, 16'hAAAA);
    push_request(cbmf_pkg::OP_PIXEL, 16'h5555);
    push_request(cbmf_pkg::OP_PIXEL, 16'hFFFF);
    push_request(cbmf_pkg::OP_PIXEL, 16'h0000);
    push_request(cbmf_pkg::OP_PIXEL, 16'h1234);
    flush_frame();

    // zero registers: one pixel, one-pixel window
    set_frame(0, 0, 0);
    push_request(cbmf_pkg::OP_PIXEL, 16'hFFFF);
    flush_frame();

    // radius above the maximum on a small frame
    set_frame(4, 3, 31);
    for (int i = 0; i < 12; i++) push_request(cbmf_pkg::OP_PIXEL, 16'hFFFF);
    flush_frame();

    // largest sizes, cut short by the next write
    set_frame(1024, 4096, 16);
    for (int i = 0; i < 4; i++) push_request(cbmf_pkg::OP_PIXEL, pick_gray());
    set_frame(2047, 8191, 1);
    for (int i = 0; i < 5; i++) push_request(cbmf_pkg::OP_PIXEL, pick_gray());

    // random frames, mostly complete, some cut short
    while (sent < 2100) begin
      if (sent > 1750) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 12);
        r = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(0, 8);
        h = $urandom_range(0, 8);
        r = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 31);
      end
      set_frame(w, h, r);
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < stop; ) begin
        if ($urandom_range(0, 9) == 0) begin
          push_request(cbmf_pkg::OP_DRAIN, 16'($urandom));
        end else begin
          push_request(cbmf_pkg::OP_PIXEL, pick_gray());
          i++;
        end
      end
      if (stop == n) flush_frame();
    end

    // wind down
    in_valid = 1'b0;
    while (pending_means != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_means == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cbmf_pkg.sv
src/cbmf_ram.sv
src/cbmf_div.sv
src/clipped_box_mean_filter.sv
src/cbmf_checker.sv
tb/cbmf_mean_checker.sv
tb/clipped_box_mean_filter_test.sv
